// ----- rtl/core/pctr_pkg.sv -----
// Shared types, constants and the CRC-16/Modbus byte update for the trailer inserter.
// No dependencies; imported by every module of the block.
package pctr_pkg;

  localparam logic [15:0] CRC_INIT = ~16'h0000;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       applied;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/pctr_frame.sv -----
// Per-packet state: running CRC and the one pending byte; turns each beat into 0..2 results.
// Depends on pctr_pkg.
module pctr_frame
  import pctr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_valid,
  input  logic [7:0] beat_data,
  input  logic       beat_last,
  output push_t      push
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_vld_r, held_vld_nxt;

  always_comb begin
    push         = '0;
    crc_nxt      = crc_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    if (beat_valid) begin
      if (!beat_last) begin
        held_nxt     = beat_data;
        held_vld_nxt = 1'b1;
        if (held_vld_r) begin
          push.n  = 2'd1;
          push.r0 = '{data: held_r, last: 1'b0, applied: 1'b0};
          crc_nxt = crc_fold(crc_r, held_r);
        end
      end else begin
        crc_nxt      = CRC_INIT;
        held_vld_nxt = 1'b0;
        if (!held_vld_r) begin
          push.n  = 2'd1;
          push.r0 = '{data: beat_data, last: 1'b1, applied: 1'b0};
        end else if (held_r == 8'h00 && beat_data == 8'h00) begin
          push.n  = 2'd2;
          push.r0 = '{data: crc_r[7:0], last: 1'b0, applied: 1'b0};
          push.r1 = '{data: crc_r[15:8], last: 1'b1, applied: 1'b1};
        end else begin
          push.n  = 2'd2;
          push.r0 = '{data: held_r, last: 1'b0, applied: 1'b0};
          push.r1 = '{data: beat_data, last: 1'b1, applied: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      held_vld_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      held_vld_r <= held_vld_nxt;
    end
    held_r <= held_nxt;
  end

endmodule

// ----- rtl/core/pctr_out_fifo.sv -----
// Result queue: takes up to two results per cycle, presents one beat per cycle while out_ready is high.
// Depends on pctr_pkg.
module pctr_out_fifo
  import pctr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr1   = wr_ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(push.n) - CNT_W'(pop);
    end
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> cnt_r <= CNT_W'(FIFO_DEPTH - 2))
    else $error("double push without room");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> {1'b0, cnt_r} == {1'b0, $past(cnt_r)} + (CNT_W+1)'($past(push.n))
                              - (CNT_W+1)'($past(pop)))
    else $error("result queue count does not track push and pop");

endmodule

// ----- rtl/core/packet_crc16_trailer_inserter.sv -----
// Top level of the CRC-16/Modbus trailer inserter.
// Depends on pctr_pkg, pctr_frame and pctr_out_fifo.
//
// Input stream: one packet byte per beat on in_tdata, in_tlast on the final
// byte. Output stream: the same bytes on out_tdata with out_tlast on the
// final one; when the last two bytes of a packet are both zero they are
// replaced by the CRC-16/Modbus (init 0xFFFF, reflected poly 0xA001) of the
// bytes before them, low byte first, and out_tuser is set on the final beat.
// out_tuser is 0 on all other beats.
// A byte is held until the next beat shows whether it is trailing, then
// appears on the output in the cycle after that beat is accepted when the
// queue is empty; the final byte of a packet is queued in the same cycle as
// the byte before it.
// Throughput: one byte per cycle while in_tready and out_tready are high;
// the final beat of a packet releases two output beats and the first beat
// of the next packet releases none, a difference absorbed by the four-entry
// result queue.
// A stalled receiver fills the queue; in_tready drops when fewer than two
// entries are free and rises again as beats drain.
// Reset sets the CRC to its initial value, drops the pending byte, empties the
// queue and holds in_tready low; no beat is lost or repeated across a stall.
module packet_crc16_trailer_inserter
  import pctr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] crc_applied
);

  push_t push;
  res_t  res;
  logic  room2;

  assign in_tready = room2 && rst_n;

  pctr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (in_tvalid && in_tready),
    .beat_data  (in_tdata),
    .beat_last  (in_tlast),
    .push       (push)
  );

  pctr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res.data;
  assign out_tlast = res.last;
  assign out_tuser = res.applied;

endmodule

// ----- sim/tb_packet_crc16_trailer_inserter.sv -----
// Testbench for packet_crc16_trailer_inserter: drives directed and random packets with random
// gaps and output stalls, and checks every output beat against a CRC-16/Modbus trailer predictor.
// Depends on pctr_pkg (CRC constants) and the RTL of the block.
`timescale 1ns / 1ps

module tb_packet_crc16_trailer_inserter
  import pctr_pkg::*;
();

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       applied;
  } out_beat_t;

  typedef logic [7:0] byte_q_t[$];

  class crc_trailer_board;
    logic [15:0] crc_acc;
    logic [7:0]  pending;
    bit          has_pending;
    out_beat_t   want_beats[$];
    int          beats_seen;
    int          trailers_inserted;

    function new();
      crc_acc = CRC_INIT;
      pending = 8'h00;
      has_pending = 0;
      beats_seen = 0;
      trailers_inserted = 0;
    endfunction

    // bit-serial reflected update
    function logic [15:0] fold(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc;
      for (int i = 0; i < 8; i++) begin
        c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void push(logic [7:0] d, logic l, logic a);
      out_beat_t e;
      e.data = d;
      e.last = l;
      e.applied = a;
      want_beats.push_back(e);
    endfunction

    function void note_input(logic [7:0] b, logic last);
      if (!last) begin
        if (has_pending) begin
          push(pending, 1'b0, 1'b0);
          crc_acc = fold(crc_acc, pending);
        end
        pending = b;
        has_pending = 1;
      end else begin
        if (!has_pending) begin
          push(b, 1'b1, 1'b0);
        end else if (pending == 8'h00 && b == 8'h00) begin
          push(crc_acc[7:0], 1'b0, 1'b0);
          push(crc_acc[15:8], 1'b1, 1'b1);
          trailers_inserted++;
        end else begin
          push(pending, 1'b0, 1'b0);
          push(b, 1'b1, 1'b0);
        end
        crc_acc = CRC_INIT;
        pending = 8'h00;
        has_pending = 0;
      end
    endfunction

    function string check_result(logic [7:0] d, logic l, logic a);
      out_beat_t e;
      string msg;
      msg = "";
      beats_seen++;
      if (want_beats.size() == 0) begin
        return $sformatf("beat %0d: unexpected output %02h last %0b crc %0b",
                         beats_seen, d, l, a);
      end
      e = want_beats.pop_front();
      if (d !== e.data || l !== e.last || a !== e.applied) begin
        msg = $sformatf("beat %0d: got %02h last %0b crc %0b, want %02h last %0b crc %0b",
                        beats_seen, d, l, a, e.data, e.last, e.applied);
      end
      return msg;
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  crc_trailer_board board;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  packets_sent = 0;
  bit  draining = 0;
  bit  held_off = 0;

  packet_crc16_trailer_inserter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", board.want_beats.size());
    $display("tb_packet_crc16_trailer_inserter: FAIL");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold the beat until accepted, then idle for a random gap unless steady is set
  task automatic send_beat(input logic [7:0] d, input logic l, input bit steady);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    board.note_input(d, l);
    bytes_sent++;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_packet(input byte_q_t pkt, input bit steady);
    foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1, steady);
    packets_sent++;
  endtask

  task automatic send_random_packet();
    byte_q_t pkt;
    int      len;
    int      r;
    bit      steady;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 32);
    else len = $urandom_range(33, 128);
    for (int i = 0; i < len; i++) begin
      pkt.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom));
    end
    if (len >= 2 && $urandom_range(0, 1)) begin
      pkt[len - 2] = 8'h00;
      pkt[len - 1] = 8'h00;
    end
    steady = ($urandom_range(0, 4) == 0);
    send_packet(pkt, steady);
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int stall_left;
    int quiet_left;
    int r;
    stall_left = 0;
    quiet_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (draining) begin
        out_tready <= 1'b1;
      end else if (!held_off && bytes_sent >= 400) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        held_off = 1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (quiet_left > 0) begin
        out_tready <= 1'b1;
        quiet_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          out_tready <= 1'b0;
          stall_left = $urandom_range(0, 3);
        end else if (r < 15) begin
          out_tready <= 1'b0;
          stall_left = $urandom_range(15, 60);
        end else begin
          out_tready <= 1'b1;
          if (r < 17) begin
            quiet_left = $urandom_range(50, 200);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      msg = board.check_result(out_tdata, out_tlast, out_tuser);
      if (msg != "") report(msg);
    end
  end

  initial begin
    int wait_cycles;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_packet('{8'h00}, 0);
    send_packet('{8'hFF}, 0);
    send_packet('{8'h00, 8'h00}, 0);
    send_packet('{8'h00, 8'hA5}, 0);
    send_packet('{8'h5A, 8'h00}, 0);
    send_packet('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
                  8'h00, 8'h00}, 1);
    send_packet('{8'hFF, 8'h00, 8'h00}, 0);
    send_packet('{8'h01, 8'h02, 8'h03}, 0);

    while (bytes_sent < 1250) send_random_packet();

    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    draining = 1;
    wait_cycles = 0;
    while (board.want_beats.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (board.want_beats.size() != 0) begin
      report($sformatf("%0d expected beats never arrived", board.want_beats.size()));
    end

    $display("sent %0d packets, %0d bytes; %0d output beats checked, %0d CRC trailers inserted",
             packets_sent, bytes_sent, board.beats_seen, board.trailers_inserted);
    $display("one long output hold-off, random gaps and stalls; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_packet_crc16_trailer_inserter: PASS");
    end else begin
      $display("tb_packet_crc16_trailer_inserter: FAIL");
    end
    $finish;
  end

endmodule
